>>> design/pwm_input_freq_duty_meter_defines.svh
// ----------------------------------------------------------------------------
// PWM meter assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PWM_INPUT_FREQ_DUTY_METER_DEFINES_SVH
`define PWM_INPUT_FREQ_DUTY_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define PWMFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwm meter assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define PWMFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwm meter assertion failed");
`else
`define PWMFD_ASSERT_IMP(lbl, ante, cons)
`define PWMFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> design/pwmfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM meter package
// Request/result payload types, divider control struct and shared codes.
// ----------------------------------------------------------------------------
package pwmfd_pkg;

    localparam int TIME_BITS_DEF = 32;

    // request codes
    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_PAIR = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_HW_MODE  = 2'd0;
    localparam logic [1:0] REG_WRAP_MAX = 2'd1;
    localparam logic [1:0] REG_REF_CLK  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic [31:0] WRAP_MAX_RST = 32'hFFFF_FFFF;
    localparam logic [26:0] REF_CLK_RST  = 27'd1_000_000;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

    localparam logic [13:0] DUTY_FULL = 14'd10000;
    localparam int          PROD_W    = 46;

    // serial divider step counts
    localparam logic [4:0] STEPS_MOD  = 5'd16;
    localparam logic [4:0] STEPS_FREQ = 5'd27;
    localparam logic [4:0] STEPS_DUTY = 5'd14;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] capture_value;
        logic [31:0] high_capture;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [31:0] period_ticks;
        logic [26:0] freq_hz;
        logic [13:0] duty_hundredths;
        logic        updated;
        logic        timed_out;
        logic        next_polarity;
    } out_item_t;

    // Launch of one serial division: the remainder starts preloaded with the
    // high part, the rest of the dividend is shifted in MSB first.
    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [31:0] dividend;
        logic [4:0]  steps;
        logic [32:0] divisor;
    } div_req_t;

endpackage

>>> design/pwmfd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM meter serial divider
// Restoring division, one quotient bit per cycle, up to 31 steps.
// ----------------------------------------------------------------------------
module pwmfd_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  pwmfd_pkg::div_req_t req,
    output logic                done,
    output logic [31:0]         quotient,
    output logic [31:0]         remainder
);
    import pwmfd_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] quo_reg;
    logic [32:0] dsr_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;
    logic [31:0] rem_next;
    logic [31:0] quo_next;

    // shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[31]};
        fits     = (shifted >= dsr_reg);
        diff     = shifted - dsr_reg;
        rem_next = fits ? diff[31:0] : shifted[31:0];
        quo_next = {quo_reg[30:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            dvd_reg <= req.dividend;
            quo_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> design/pwm_input_freq_duty_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM input frequency and duty meter
// One-channel PWM capture evaluation with serial division and timeout.
// ----------------------------------------------------------------------------
// The meter takes one request at a time and returns exactly one result per
// request. Edge, pair and unused requests go from acceptance straight to the
// result state. An evaluate runs its arithmetic through a single bit-serial
// restoring divider (one quotient bit per cycle): for three software captures
// it first reduces each modulo wrap_max+1 (16 steps each), a hardware pair
// skips this; then it divides the reference clock by the period (27 steps)
// and, when high < period, the scaled high time by the period (14 steps). An
// evaluate that measures nothing only runs the timeout check. A finished
// result sits in an output register; the next request is accepted while it
// waits, and its own result holds until the previous one is taken.
// Configuration is an APB port at byte addresses 0, 4, 8, 12 (hw_mode,
// wrap_max, ref_clock_hz, timeout_ms); the user must write it only while the
// meter is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "pwm_input_freq_duty_meter_defines.svh"

module pwm_input_freq_duty_meter
#(
    parameter int TIME_BITS = pwmfd_pkg::TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  pwmfd_pkg::in_item_t  req_item,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output pwmfd_pkg::out_item_t res_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import pwmfd_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD_FR = 4'd1;
    localparam logic [3:0] S_MOD_FE = 4'd2;
    localparam logic [3:0] S_MOD_SR = 4'd3;
    localparam logic [3:0] S_DIFF   = 4'd4;
    localparam logic [3:0] S_MEAS   = 4'd5;
    localparam logic [3:0] S_FREQ   = 4'd6;
    localparam logic [3:0] S_DUTY   = 4'd7;
    localparam logic [3:0] S_TMO    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // software capture phase: how many of the first rise, fall and second rise edges are stored
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;
    localparam logic [1:0] PH_FULL = 2'd3;

    localparam logic POL_RISE = 1'b0;
    localparam logic POL_FALL = 1'b1;

    logic [3:0]  state_reg;

    // configuration
    logic        hw_mode_reg;
    logic [31:0] wrap_max_reg;
    logic [26:0] ref_clk_reg;
    logic [15:0] timeout_reg;

    // capture state
    logic [1:0]           phase_reg;
    logic [31:0]          first_rise_reg;
    logic [31:0]          fall_edge_reg;
    logic [31:0]          second_rise_reg;
    logic [31:0]          pair_period_reg;
    logic [31:0]          pair_high_reg;
    logic                 pair_ready_reg;
    logic [TIME_BITS-1:0] last_edge_reg;
    logic                 polarity_reg;

    // held measurement
    logic [31:0] held_period_reg;
    logic [26:0] held_freq_reg;
    logic [13:0] held_duty_reg;
    logic        updated_reg;
    logic        timed_out_reg;

    // datapath working registers
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]          meas_per_reg;
    logic [31:0]          meas_hi_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 sat_reg;

    logic      res_valid_reg;
    out_item_t res_item_reg;

    logic      req_acc;
    logic      res_free;
    logic      cfg_wr;
    logic      eval_sw_full;

    logic [32:0]          modulus;
    logic [32:0]          per_wrap;
    logic [32:0]          hi_wrap;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;

    div_req_t    div_req;
    logic        div_done;
    logic [31:0] div_quo;
    logic [31:0] div_rem;

    // one request in flight; its result may wait behind the output register
    assign req_stall = (state_reg != S_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign eval_sw_full = !hw_mode_reg && (phase_reg == PH_FULL);

    // Captures are reduced modulo wrap_max+1 before this point, so each
    // difference lands below the modulus and needs at most one wrap add.
    assign modulus = {1'b0, wrap_max_reg} + 33'd1;

    always_comb
    begin
        if (second_rise_reg >= first_rise_reg)
            per_wrap = {1'b0, second_rise_reg} - {1'b0, first_rise_reg};
        else
            per_wrap = modulus - {1'b0, first_rise_reg} + {1'b0, second_rise_reg};
        if (fall_edge_reg >= first_rise_reg)
            hi_wrap = {1'b0, fall_edge_reg} - {1'b0, first_rise_reg};
        else
            hi_wrap = modulus - {1'b0, first_rise_reg} + {1'b0, fall_edge_reg};
    end

    // no-edge timeout on the wrapping millisecond clock
    assign elapsed = now_reg - last_edge_reg;
    assign expired = (elapsed > TIME_BITS'(timeout_reg));

    // Divider launches. A modulo preloads the top 16 capture bits, which
    // are already below any legal modulus, and runs the low 16 bits through.
    // The duty division only runs when high < period, so its quotient fits
    // in 14 bits and the top 32 product bits form the starting remainder.
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc && (req_item.req_type == REQ_EVAL) && eval_sw_full)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {16'd0, first_rise_reg[31:16]};
                    div_req.dividend = {first_rise_reg[15:0], 16'd0};
                    div_req.steps    = STEPS_MOD;
                    div_req.divisor  = modulus;
                end
            end
            S_MOD_FR:
            begin
                if (div_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {16'd0, fall_edge_reg[31:16]};
                    div_req.dividend = {fall_edge_reg[15:0], 16'd0};
                    div_req.steps    = STEPS_MOD;
                    div_req.divisor  = modulus;
                end
            end
            S_MOD_FE:
            begin
                if (div_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {16'd0, second_rise_reg[31:16]};
                    div_req.dividend = {second_rise_reg[15:0], 16'd0};
                    div_req.steps    = STEPS_MOD;
                    div_req.divisor  = modulus;
                end
            end
            S_MEAS:
            begin
                if (meas_per_reg != 32'd0)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = {ref_clk_reg, 5'd0};
                    div_req.steps    = STEPS_FREQ;
                    div_req.divisor  = {1'b0, meas_per_reg};
                end
            end
            S_FREQ:
            begin
                if (div_done && !sat_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = prod_reg[45:14];
                    div_req.dividend = {prod_reg[13:0], 18'd0};
                    div_req.steps    = STEPS_DUTY;
                    div_req.divisor  = {1'b0, meas_per_reg};
                end
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    pwmfd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            hw_mode_reg     <= 1'b0;
            wrap_max_reg    <= WRAP_MAX_RST;
            ref_clk_reg     <= REF_CLK_RST;
            timeout_reg     <= TIMEOUT_RST;
            phase_reg       <= PH_NONE;
            first_rise_reg  <= '0;
            fall_edge_reg   <= '0;
            second_rise_reg <= '0;
            pair_period_reg <= '0;
            pair_high_reg   <= '0;
            pair_ready_reg  <= 1'b0;
            last_edge_reg   <= '0;
            polarity_reg    <= POL_RISE;
            held_period_reg <= '0;
            held_freq_reg   <= '0;
            held_duty_reg   <= '0;
            updated_reg     <= 1'b0;
            timed_out_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_HW_MODE:  hw_mode_reg  <= pwdata[0];
                    REG_WRAP_MAX: wrap_max_reg <= pwdata;
                    REG_REF_CLK:  ref_clk_reg  <= pwdata[26:0];
                    REG_TIMEOUT:  timeout_reg  <= pwdata[15:0];
                    default:      hw_mode_reg  <= hw_mode_reg;
                endcase
            end

            // drop the result once taken; a new one below overrides
            if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        updated_reg   <= 1'b0;
                        timed_out_reg <= 1'b0;
                        state_reg     <= S_DONE;
                        case (req_item.req_type)
                            REQ_EDGE:
                            begin
                                if (!hw_mode_reg)
                                begin
                                    last_edge_reg <= req_item.now_ms[TIME_BITS-1:0];
                                    case (phase_reg)
                                        PH_NONE:
                                        begin
                                            first_rise_reg <= req_item.capture_value;
                                            polarity_reg   <= POL_FALL;
                                            phase_reg      <= PH_RISE;
                                        end
                                        PH_RISE:
                                        begin
                                            fall_edge_reg <= req_item.capture_value;
                                            polarity_reg  <= POL_RISE;
                                            phase_reg     <= PH_FALL;
                                        end
                                        PH_FALL:
                                        begin
                                            second_rise_reg <= req_item.capture_value;
                                            phase_reg       <= PH_FULL;
                                        end
                                        default:
                                        begin
                                            // all three pending: drop the value
                                            phase_reg <= PH_FULL;
                                        end
                                    endcase
                                end
                            end
                            REQ_PAIR:
                            begin
                                if (hw_mode_reg)
                                begin
                                    last_edge_reg   <= req_item.now_ms[TIME_BITS-1:0];
                                    pair_period_reg <= req_item.capture_value;
                                    pair_high_reg   <= req_item.high_capture;
                                    pair_ready_reg  <= 1'b1;
                                end
                            end
                            REQ_EVAL:
                            begin
                                if (hw_mode_reg)
                                begin
                                    if (pair_ready_reg)
                                    begin
                                        pair_ready_reg <= 1'b0;
                                        state_reg      <= S_MEAS;
                                    end
                                    else
                                        state_reg <= S_TMO;
                                end
                                else if (eval_sw_full)
                                    state_reg <= S_MOD_FR;
                                else
                                    state_reg <= S_TMO;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MOD_FR:
                begin
                    if (div_done)
                    begin
                        first_rise_reg <= div_rem;
                        state_reg      <= S_MOD_FE;
                    end
                end
                S_MOD_FE:
                begin
                    if (div_done)
                    begin
                        fall_edge_reg <= div_rem;
                        state_reg     <= S_MOD_SR;
                    end
                end
                S_MOD_SR:
                begin
                    if (div_done)
                    begin
                        second_rise_reg <= div_rem;
                        state_reg       <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    // captures are consumed whether or not the period is zero
                    phase_reg <= PH_NONE;
                    state_reg <= S_MEAS;
                end
                S_MEAS:
                begin
                    if (meas_per_reg != 32'd0)
                    begin
                        held_period_reg <= meas_per_reg;
                        updated_reg     <= 1'b1;
                        state_reg       <= S_FREQ;
                    end
                    else
                        state_reg <= S_TMO;
                end
                S_FREQ:
                begin
                    if (div_done)
                    begin
                        held_freq_reg <= div_quo[26:0];
                        if (sat_reg)
                        begin
                            held_duty_reg <= DUTY_FULL;
                            state_reg     <= S_TMO;
                        end
                        else
                            state_reg <= S_DUTY;
                    end
                end
                S_DUTY:
                begin
                    if (div_done)
                    begin
                        held_duty_reg <= div_quo[13:0];
                        state_reg     <= S_TMO;
                    end
                end
                S_TMO:
                begin
                    if (expired)
                    begin
                        held_period_reg <= '0;
                        held_freq_reg   <= '0;
                        held_duty_reg   <= '0;
                        phase_reg       <= PH_NONE;
                        polarity_reg    <= POL_RISE;
                        timed_out_reg   <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold here until the output register is free
                    if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            now_reg <= req_item.now_ms[TIME_BITS-1:0];
            if (hw_mode_reg)
            begin
                meas_per_reg <= pair_period_reg;
                meas_hi_reg  <= pair_high_reg;
            end
        end
        if (state_reg == S_DIFF)
        begin
            meas_per_reg <= per_wrap[31:0];
            meas_hi_reg  <= hi_wrap[31:0];
        end
        if (state_reg == S_MEAS)
        begin
            prod_reg <= {14'd0, meas_hi_reg} * {32'd0, DUTY_FULL};
            sat_reg  <= (meas_hi_reg >= meas_per_reg);
        end
        if ((state_reg == S_DONE) && res_free)
        begin
            res_item_reg.period_ticks    <= held_period_reg;
            res_item_reg.freq_hz         <= held_freq_reg;
            res_item_reg.duty_hundredths <= held_duty_reg;
            res_item_reg.updated         <= updated_reg;
            res_item_reg.timed_out       <= timed_out_reg;
            res_item_reg.next_polarity   <= polarity_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_HW_MODE:  prdata = {31'd0, hw_mode_reg};
            REG_WRAP_MAX: prdata = wrap_max_reg;
            REG_REF_CLK:  prdata = {5'd0, ref_clk_reg};
            REG_TIMEOUT:  prdata = {16'd0, timeout_reg};
            default:      prdata = '0;
        endcase
    end

    // a timed-out result reports zeroed values and rising polarity
    `PWMFD_ASSERT_IMP(a_timeout_zeroes, res_valid && res_item.timed_out, (res_item.period_ticks == 32'd0) && (res_item.freq_hz == 27'd0) && (res_item.duty_hundredths == 14'd0) && (res_item.next_polarity == POL_RISE))
    // a fresh measurement that did not time out has a nonzero period
    `PWMFD_ASSERT_IMP(a_update_period, res_valid && res_item.updated && !res_item.timed_out, res_item.period_ticks != 32'd0)
    // the divider only finishes while the sequencer waits for it
    `PWMFD_ASSERT_IMP(a_div_done_state, div_done, (state_reg == S_MOD_FR) || (state_reg == S_MOD_FE) || (state_reg == S_MOD_SR) || (state_reg == S_FREQ) || (state_reg == S_DUTY))
    // the period difference step always consumes the captures
    `PWMFD_ASSERT_NXT(a_diff_consumes, state_reg == S_DIFF, (state_reg == S_MEAS) && (phase_reg == PH_NONE))

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM meter testbench
// Drives software edges, hardware pairs and evaluate requests into the meter
// under several register settings, predicts results with a cycle-free model
// (or takes a directed row's own), and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;
    import pwmfd_pkg::*;

    // request code the block leaves unused; it must be ignored
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // capture polarity reported as next_polarity
    localparam logic POL_RISE = 1'b0;
    localparam logic POL_FALL = 1'b1;

    // request stalls last one evaluate plus any wait for the output register, so give the run plenty of room
    localparam longint unsigned RUN_LIMIT_NS = 64'd20_000_000;
    localparam int DIR_ROWS = 29;

    // progress through the first rise, fall and second rise software capture
    typedef enum logic [1:0] {
        CAPT_EMPTY = 2'd0,
        CAPT_FIRST = 2'd1,
        CAPT_FALL  = 2'd2,
        CAPT_FULL  = 2'd3
    } capt_state_e;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_REG = 1'b1
    } row_kind_e;

    // a request waiting to be sent; a typed row carries its own result
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } req_entry_t;

    typedef struct packed {
        row_kind_e   kind;
        req_entry_t  entry;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
    } step_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    in_item_t    req_item = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_item_t   res_item;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    pwm_input_freq_duty_meter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor copy of the meter: registers and measurement state, starting
    // from their reset values. TIME_BITS is left at 32, so time differences
    // wrap at 2^32 with no further masking.
    // ------------------------------------------------------------------------
    logic        cfg_hw      = 1'b0;
    logic [31:0] cfg_wrap    = WRAP_MAX_RST;
    logic [26:0] cfg_ref     = REF_CLK_RST;
    logic [15:0] cfg_timeout = TIMEOUT_RST;

    capt_state_e capt_state  = CAPT_EMPTY;
    logic [31:0] rise0       = 32'd0;
    logic [31:0] fall_cap    = 32'd0;
    logic [31:0] rise1       = 32'd0;
    logic [31:0] pair_per    = 32'd0;
    logic [31:0] pair_hi     = 32'd0;
    logic        pair_ready  = 1'b0;
    logic [31:0] last_edge   = 32'd0;
    logic        polarity    = POL_RISE;
    logic [31:0] held_per    = 32'd0;
    logic [26:0] held_freq   = 27'd0;
    logic [13:0] held_duty   = 14'd0;

    req_entry_t  req_backlog[$];
    out_item_t   meter_results_due[$];
    step_row_t   dir_rows [DIR_ROWS];
    req_entry_t  req_slot;
    out_item_t   predicted;
    logic [31:0] ms_clock = 32'd0;

    int unsigned live_reqs     = 0;
    int unsigned sent_count    = 0;
    int unsigned result_count  = 0;
    int unsigned update_count  = 0;
    int unsigned timeout_count = 0;
    int unsigned reg_writes    = 0;
    int unsigned mismatches    = 0;

    // Distance from earlier to later capture, modulo wrap_max+1.
    function automatic logic [31:0] tick_span(logic [31:0] later, logic [31:0] earlier);
        logic [32:0] modulus;
        logic [32:0] a;
        logic [32:0] b;
        logic [32:0] d;
        modulus = {1'b0, cfg_wrap} + 33'd1;
        a = {1'b0, later} % modulus;
        b = {1'b0, earlier} % modulus;
        d = (a >= b) ? (a - b) : (modulus - b + a);
        return d[31:0];
    endfunction

    // Latch a new measurement; a zero period leaves the held values alone.
    function automatic logic take_measure(logic [31:0] per, logic [31:0] hi);
        logic [63:0] duty;
        if (per == 32'd0)
            return 1'b0;
        held_per  = per;
        held_freq = 27'({5'd0, cfg_ref} / per);
        duty = ({32'd0, hi} * 64'd10000) / {32'd0, per};
        if (duty > {50'd0, DUTY_FULL})
            duty = {50'd0, DUTY_FULL};
        held_duty = duty[13:0];
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted request and return its result.
    function automatic out_item_t meter_step(in_item_t it);
        out_item_t   r;
        logic        upd;
        logic        tmo;
        logic [31:0] since;
        upd = 1'b0;
        tmo = 1'b0;
        if (it.req_type == REQ_EDGE && !cfg_hw) begin
            // the edge time counts even when all three captures are full
            last_edge = it.now_ms;
            case (capt_state)
                CAPT_EMPTY:
                begin
                    rise0 = it.capture_value;
                    polarity = POL_FALL;
                    capt_state = CAPT_FIRST;
                end
                CAPT_FIRST:
                begin
                    fall_cap = it.capture_value;
                    polarity = POL_RISE;
                    capt_state = CAPT_FALL;
                end
                CAPT_FALL:
                begin
                    rise1 = it.capture_value;
                    capt_state = CAPT_FULL;
                end
                default: ;
            endcase
        end
        else if (it.req_type == REQ_PAIR && cfg_hw) begin
            last_edge  = it.now_ms;
            pair_per   = it.capture_value;
            pair_hi    = it.high_capture;
            pair_ready = 1'b1;
        end
        else if (it.req_type == REQ_EVAL) begin
            if (cfg_hw) begin
                if (pair_ready) begin
                    upd = take_measure(pair_per, pair_hi);
                    pair_ready = 1'b0;
                end
            end
            else if (capt_state == CAPT_FULL) begin
                upd = take_measure(tick_span(rise1, rise0), tick_span(fall_cap, rise0));
                capt_state = CAPT_EMPTY;
            end
            // timeout comes after the measurement and may wipe it at once
            since = it.now_ms - last_edge;
            if (since > {16'd0, cfg_timeout}) begin
                held_per   = 32'd0;
                held_freq  = 27'd0;
                held_duty  = 14'd0;
                capt_state = CAPT_EMPTY;
                polarity   = POL_RISE;
                tmo        = 1'b1;
            end
        end
        r.period_ticks    = held_per;
        r.freq_hz         = held_freq;
        r.duty_hundredths = held_duty;
        r.updated         = upd;
        r.timed_out       = tmo;
        r.next_polarity   = polarity;
        return r;
    endfunction

    function automatic in_item_t make_req(logic [1:0] code, logic [31:0] cap,
                                          logic [31:0] hi, logic [31:0] now);
        in_item_t it;
        it.req_type      = code;
        it.capture_value = cap;
        it.high_capture  = hi;
        it.now_ms        = now;
        return it;
    endfunction

    function automatic step_row_t req_row(logic [1:0] code, logic [31:0] cap,
                                          logic [31:0] hi, logic [31:0] now);
        step_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.entry.req = make_req(code, cap, hi, now);
        return r;
    endfunction

    // Request row with its result written out by hand.
    function automatic step_row_t known_row(logic [1:0] code, logic [31:0] cap,
                                            logic [31:0] hi, logic [31:0] now,
                                            logic [31:0] per, logic [26:0] freq,
                                            logic [13:0] duty, logic upd, logic tmo,
                                            logic pol);
        step_row_t r;
        r = req_row(code, cap, hi, now);
        r.entry.typed                = 1'b1;
        r.entry.want.period_ticks    = per;
        r.entry.want.freq_hz         = freq;
        r.entry.want.duty_hundredths = duty;
        r.entry.want.updated         = upd;
        r.entry.want.timed_out       = tmo;
        r.entry.want.next_polarity   = pol;
        return r;
    endfunction

    function automatic step_row_t reg_row(logic [1:0] idx, logic [31:0] val);
        step_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Queue a request; count it only when the current mode acts on it.
    function automatic void queue_req(req_entry_t e);
        req_backlog.push_back(e);
        if (!((e.req.req_type == REQ_EDGE && cfg_hw) ||
              (e.req.req_type == REQ_PAIR && !cfg_hw) ||
              e.req.req_type == REQ_UNUSED))
            live_reqs++;
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        result_count++;
        if (got.updated)
            update_count++;
        if (got.timed_out)
            timeout_count++;
        if (meter_results_due.size() == 0) begin
            if (mismatches < 10)
                $display("ERROR %0t: result with no request outstanding (per=%0d freq=%0d)",
                         $time, got.period_ticks, got.freq_hz);
            mismatches++;
            return;
        end
        want = meter_results_due.pop_front();
        if (got.period_ticks !== want.period_ticks || got.freq_hz !== want.freq_hz ||
            got.duty_hundredths !== want.duty_hundredths ||
            got.updated !== want.updated || got.timed_out !== want.timed_out ||
            got.next_polarity !== want.next_polarity) begin
            if (mismatches < 10) begin
                $display("MISMATCH %0t result %0d:", $time, result_count);
                $display("  expected per=%0d freq=%0d duty=%0d upd=%0b tmo=%0b pol=%0b",
                         want.period_ticks, want.freq_hz, want.duty_hundredths,
                         want.updated, want.timed_out, want.next_polarity);
                $display("  actual   per=%0d freq=%0d duty=%0d upd=%0b tmo=%0b pol=%0b",
                         got.period_ticks, got.freq_hz, got.duty_hundredths,
                         got.updated, got.timed_out, got.next_polarity);
            end
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side: send in bursts of random length with random gaps, some
    // long enough to span a whole evaluate, some runs with no gap at all.
    // Hold the payload while stalled; predict at the accepting edge.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req_item  <= '0;
        end
        else begin
            if (req_valid && !req_stall) begin
                sent_count++;
                predicted = meter_step(req_slot.req);
                meter_results_due.push_back(req_slot.typed ? req_slot.want : predicted);
            end
            if (!req_valid || !req_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0) begin
                    req_slot = req_backlog.pop_front();
                    req_item  <= req_slot.req;
                    req_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(9))
                            0, 1:    gap_left = 0;
                            2:       gap_left = $urandom_range(30, 150);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                    burst_left--;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall with a duty that changes every so often, from never
    // to most cycles. Check every result taken.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned stall_pct  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else begin
            if (res_valid && !res_stall)
                check_result(res_item);
            if (stall_left == 0) begin
                stall_left = $urandom_range(10, 200);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stall_left--;
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Wait until every queued request is sent and every result is back.
    task automatic wait_idle();
        while (req_backlog.size() != 0 || req_valid || meter_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register over APB, mirror it in the predictor, read it back.
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        reg_writes++;
        mask = 32'd0;
        case (idx)
            REG_HW_MODE:
            begin
                mask = 32'h0000_0001;
                cfg_hw = val[0];
            end
            REG_WRAP_MAX:
            begin
                mask = 32'hFFFF_FFFF;
                cfg_wrap = val;
            end
            REG_REF_CLK:
            begin
                mask = 32'h07FF_FFFF;
                cfg_ref = val[26:0];
            end
            REG_TIMEOUT:
            begin
                mask = 32'h0000_FFFF;
                cfg_timeout = val[15:0];
            end
            default: ;
        endcase
        // turn the same select into a read of the register just written
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (val & mask)) begin
            if (mismatches < 10)
                $display("MISMATCH %0t: register %0d read 0x%08h, wrote 0x%08h",
                         $time, idx, got, val & mask);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] pick_period();
        case ($urandom_range(9))
            0:          return $urandom_range(0, 2);
            1, 2, 3:    return $urandom_range(1, 1000);
            4, 5, 6:    return $urandom_range(1, 65535);
            7:          return cfg_wrap;
            default:    return $urandom_range(1, cfg_wrap);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic under the current settings. Most of it is complete
    // measurements (rise, fall and second rise edges, or a pair, then an
    // evaluate) with random periods, high times and delays around the timeout,
    // some with short or extra edge runs; the rest is noise: any code, any fields.
    // ------------------------------------------------------------------------
    task automatic run_phase(int unsigned quota);
        req_entry_t  e;
        logic [32:0] modulus;
        logic [32:0] base;
        logic [31:0] per;
        logic [31:0] hi;
        logic [31:0] caps [4];
        logic [31:0] delay;
        int unsigned goal;
        int unsigned edges;
        goal = live_reqs + quota;
        modulus = {1'b0, cfg_wrap} + 33'd1;
        ms_clock = $urandom;
        while (live_reqs < goal) begin
            e = '0;
            if ($urandom_range(99) < 80) begin
                per = pick_period();
                case ($urandom_range(9))
                    7:       hi = 32'd0;
                    8:       hi = per + $urandom_range(1, 100);
                    9:       hi = $urandom;
                    default: hi = $urandom_range(0, per);
                endcase
                if (cfg_hw) begin
                    ms_clock += $urandom_range(0, cfg_timeout / 4);
                    e.req = make_req(REQ_PAIR, per, hi, ms_clock);
                    queue_req(e);
                end
                else begin
                    // place the edges inside the counter range, wrapping at wrap_max
                    base = {1'b0, $urandom} % modulus;
                    caps[0] = base[31:0];
                    caps[1] = 32'((base + {1'b0, hi}) % modulus);
                    caps[2] = 32'((base + {1'b0, per}) % modulus);
                    caps[3] = $urandom;
                    case ($urandom_range(9))
                        0:       edges = 2;
                        1:       edges = 4;
                        default: edges = 3;
                    endcase
                    for (int k = 0; k < edges; k++) begin
                        ms_clock += $urandom_range(0, cfg_timeout / 8);
                        e.req = make_req(REQ_EDGE,
                                         ($urandom_range(11) == 0) ? $urandom : caps[k],
                                         $urandom, ms_clock);
                        queue_req(e);
                    end
                end
                // land the evaluate just inside, at, or past the timeout
                case ($urandom_range(9))
                    0:       delay = {16'd0, cfg_timeout};
                    1:       delay = {16'd0, cfg_timeout} + 32'd1;
                    2:       delay = {16'd0, cfg_timeout} + $urandom_range(2, 100000);
                    default: delay = $urandom_range(0, cfg_timeout / 2);
                endcase
                ms_clock += delay;
                e.req = make_req(REQ_EVAL, $urandom, $urandom, ms_clock);
                queue_req(e);
            end
            else begin
                e.req = make_req(2'($urandom_range(3)), $urandom, $urandom,
                                 ($urandom_range(4) == 0) ? $urandom :
                                 ms_clock + $urandom_range(0, cfg_timeout));
                queue_req(e);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed rows, then random phases over a spread
    // of register settings, including every extreme.
    // ------------------------------------------------------------------------
    initial
    begin
        logic        hw;
        logic [31:0] wrap;
        logic [31:0] refclk;
        logic [31:0] tmo;

        // Directed rows start in software mode with the reset registers:
        // wrap at 2^32, 1 MHz ticks, 1000 ms timeout.
        dir_rows = '{
            // evaluate straight after reset: nothing held, nothing pending
            known_row(REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, POL_RISE),
            // first rise and fall flip the polarity to capture next
            known_row(REQ_EDGE, 100, 0, 10, 0, 0, 0, 0, 0, POL_FALL),
            known_row(REQ_EDGE, 350, 0, 11, 0, 0, 0, 0, 0, POL_RISE),
            req_row(REQ_EDGE, 1100, 0, 12),
            // fourth edge: value dropped, time still taken
            req_row(REQ_EDGE, 5, 0, 13),
            known_row(REQ_EVAL, 0, 0, 14, 1000, 1000, 2500, 1, 0, POL_RISE),
            // pair in software mode and the unused code: both ignored
            req_row(REQ_PAIR, 50, 25, 15),
            req_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            // exactly timeout_ms since the dropped edge: still alive
            known_row(REQ_EVAL, 0, 0, 1013, 1000, 1000, 2500, 0, 0, POL_RISE),
            known_row(REQ_EVAL, 0, 0, 1014, 0, 0, 0, 0, 1, POL_RISE),
            // captures wrapping past the counter top; fall after second rise
            // gives a high time longer than the period, so duty saturates
            req_row(REQ_EDGE, 32'hFFFF_FFF0, 0, 2000),
            req_row(REQ_EDGE, 32'h0000_0020, 0, 2000),
            req_row(REQ_EDGE, 32'h0000_0010, 0, 2001),
            req_row(REQ_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2001),
            // zero period: no measurement, captures consumed
            req_row(REQ_EDGE, 500, 0, 3000),
            req_row(REQ_EDGE, 500, 0, 3000),
            req_row(REQ_EDGE, 500, 0, 3000),
            req_row(REQ_EVAL, 0, 0, 3000),
            // time wraps between the edges and the evaluate; the new
            // measurement and the timeout land on the same evaluate
            req_row(REQ_EDGE, 0, 0, 32'hFFFF_FF00),
            req_row(REQ_EDGE, 7, 0, 32'hFFFF_FF00),
            req_row(REQ_EDGE, 20, 0, 32'hFFFF_FF00),
            known_row(REQ_EVAL, 0, 0, 32'h0000_0400, 0, 0, 0, 1, 1, POL_RISE),
            reg_row(REG_HW_MODE, 32'd1),
            // largest pair: frequency rounds to zero, duty full scale
            req_row(REQ_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h500),
            known_row(REQ_EVAL, 0, 0, 32'h500, 32'hFFFF_FFFF, 0, 10000, 1, 0, POL_RISE),
            // software edge in hardware mode is ignored; evaluate with no
            // pair pending only runs the timeout
            req_row(REQ_EDGE, 123, 0, 32'h502),
            known_row(REQ_EVAL, 0, 0, 32'h7000, 0, 0, 0, 0, 1, POL_RISE),
            // smallest nonzero period
            req_row(REQ_PAIR, 1, 0, 32'h7001),
            known_row(REQ_EVAL, 0, 0, 32'h7001, 1, 1000000, 0, 1, 0, POL_RISE)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_idle();
                reg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                queue_req(dir_rows[i].entry);
        end

        // First four phases pin the extremes, the rest pick at random.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:
                begin
                    hw = 1'b0; wrap = 32'hFFFF_FFFF; refclk = 100_000_000; tmo = 65535;
                end
                1:
                begin
                    hw = 1'b1; wrap = 32'h0000_FFFF; refclk = 1; tmo = 1;
                end
                2:
                begin
                    hw = 1'b0; wrap = 32'h0000_FFFF; refclk = 1_000_000; tmo = 1;
                end
                3:
                begin
                    hw = 1'b1; wrap = 32'hFFFF_FFFF; refclk = 100_000_000; tmo = 1000;
                end
                default:
                begin
                    hw     = 1'($urandom_range(1));
                    wrap   = $urandom_range(1) ? 32'h0000_FFFF
                                               : $urandom_range(65535, 32'hFFFF_FFFF);
                    refclk = $urandom_range(1, 100_000_000);
                    tmo    = $urandom_range(1, 65535);
                end
            endcase
            wait_idle();
            reg_write(REG_HW_MODE, {31'd0, hw});
            reg_write(REG_WRAP_MAX, wrap);
            reg_write(REG_REF_CLK, refclk);
            reg_write(REG_TIMEOUT, tmo);
            run_phase(110);
        end

        // drain, then leave room for any stray result
        wait_idle();
        repeat (150) @(posedge clk);

        $display("Sent %0d requests (%0d acted on) over %0d register writes in both modes;",
                 sent_count, live_reqs, reg_writes);
        $display("checked %0d results: %0d new measurements, %0d timeouts, %0d mismatches.",
                 result_count, update_count, timeout_count, mismatches);
        if (mismatches == 0 && meter_results_due.size() == 0)
            $display("** pwm_input_freq_duty_meter: PASSED **");
        else
            $display("** pwm_input_freq_duty_meter: FAILED **");
        $finish;
    end

    // Hard stop if the meter hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results still outstanding",
                 meter_results_due.size());
        $display("** pwm_input_freq_duty_meter: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/pwmfd_pkg.sv
design/pwmfd_div.sv
design/pwm_input_freq_duty_meter.sv
bench/tb.sv
